// ===== hw/rtl/sdfm_pkg.sv =====
package sdfm_pkg;

  localparam int unsigned GainW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_AUX_END = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FOUT = 2'd1;
  localparam logic [1:0] MODE_MIX = 2'd2;
  localparam logic [1:0] MODE_FIN = 2'd3;
  localparam logic [1:0] PEND_NONE = 2'd0;

  localparam logic [CfgIdxW-1:0] REG_FLOOR_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_AUX_GAIN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FADE_STEPS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RAMP_STEP = 2'd3;

  localparam logic [15:0] UNITY15 = 16'd32768;
  localparam logic [GainW-1:0] UNITY23 = 24'h800000;
  localparam logic [GainW-1:0] ACC_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0] mode;
    logic       status;
  } res_ctrl_t;

endpackage

// ===== hw/rtl/sdfm_if.sv =====
interface sdfm_in_if #(
  parameter int unsigned SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [SampleBits-1:0] main_sample;
  logic signed [SampleBits-1:0] aux_sample;
  logic                         aux_valid;

  modport source (output valid, op, main_sample, aux_sample, aux_valid, input ready);
  modport sink (input valid, op, main_sample, aux_sample, aux_valid, output ready);
endinterface

interface sdfm_out_if #(
  parameter int unsigned SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] out_sample;
  logic [1:0]                   mode_now;
  logic                         status;

  modport source (output valid, out_sample, mode_now, status, input ready);
  modport sink (input valid, out_sample, mode_now, status, output ready);
endinterface

interface sdfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/stream_duck_fade_mixer.sv =====
// Channel  | Dir | Payload                                    | Handshake
// in_i     | in  | op, main_sample, aux_sample, aux_valid     | valid / ready
// out_o    | out | out_sample, mode_now, status               | valid / ready
// cfg_i    | in  | index, data                                | valid / ready
//
// One transaction is accepted per cycle while the output is not stalled.
// Mode, pending request, fade count and ramp accumulator update in the cycle of acceptance.
// The gain multiply and saturation run in a three-register pipeline that fills bubbles.
// Reset clears the mode state and loads the default gains, fade length and ramp step.
// A stalled output holds its result while upstream stages keep filling.
module stream_duck_fade_mixer #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  sdfm_in_if.sink    in_i,
  sdfm_out_if.source out_o,
  sdfm_cfg_if.sink   cfg_i
);
  import sdfm_pkg::*;

  logic [15:0]      floor_q, aux_gain_q, steps_q;
  logic [GainW-1:0] step_q;
  logic [1:0]       mode_q, mode_d, pend_q, pend_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [GainW-1:0] acc_q, acc_d;

  logic             in_acc;
  logic             op_ready;
  logic [15:0]      fl, ag;
  logic [GainW-1:0] fl23, gm, ga, g_out;
  logic [GainW:0]   g_in, acc_sum;
  res_ctrl_t        ctrl, res_ctrl;

  assign in_i.ready = op_ready;
  assign in_acc = in_i.valid && op_ready;
  assign cfg_i.ready = 1'b1;

  assign fl = (floor_q > UNITY15) ? UNITY15 : floor_q;
  assign ag = (aux_gain_q > UNITY15) ? UNITY15 : aux_gain_q;
  assign fl23 = {fl[15:0], 8'h00};

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    gm = '0;
    ga = '0;
    g_in = '0;
    g_out = '0;
    acc_sum = '0;
    ctrl.status = 1'b0;
    if (in_acc) begin
      case (in_i.op)
        OP_START: begin
          if (mode_q != MODE_IDLE) begin
            ctrl.status = 1'b1;
          end else begin
            pend_d = MODE_FOUT;
            cnt_d = '0;
            acc_d = '0;
          end
        end
        OP_STOP, OP_AUX_END: begin
          pend_d = MODE_FIN;
        end
        default: begin
          if (mode_d == MODE_FOUT && cnt_d >= steps_q) begin
            mode_d = MODE_MIX;
            cnt_d = '0;
            acc_d = '0;
          end
          if (mode_d == MODE_MIX && pend_d == MODE_FOUT) begin
            pend_d = PEND_NONE;
          end else if (mode_d == MODE_IDLE && pend_d == MODE_FIN) begin
            pend_d = PEND_NONE;
          end else if (pend_d != PEND_NONE) begin
            mode_d = pend_d;
            pend_d = PEND_NONE;
          end
          case (mode_d)
            MODE_FOUT, MODE_FIN: begin
              if (cnt_d < steps_q) begin
                g_in = {1'b0, fl23} + {1'b0, acc_d};
                g_out = (acc_d > UNITY23) ? '0 : UNITY23 - acc_d;
                if (mode_d == MODE_FIN) begin
                  gm = (g_in > {1'b0, UNITY23}) ? UNITY23 : g_in[GainW-1:0];
                end else begin
                  gm = (g_out < fl23) ? fl23 : g_out;
                end
                cnt_d = cnt_d + 16'd1;
                acc_sum = {1'b0, acc_d} + {1'b0, step_q};
                acc_d = acc_sum[GainW] ? ACC_MAX : acc_sum[GainW-1:0];
              end else begin
                gm = UNITY23;
              end
              if (cnt_d >= steps_q) begin
                mode_d = (mode_d == MODE_FIN) ? MODE_IDLE : MODE_MIX;
                cnt_d = '0;
                acc_d = '0;
              end
            end
            MODE_MIX: begin
              gm = fl23;
              ga = in_i.aux_valid ? {ag, 8'h00} : '0;
            end
            default: begin
              gm = UNITY23;
            end
          endcase
        end
      endcase
    end
    ctrl.mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= UNITY15;
      aux_gain_q <= UNITY15;
      steps_q <= 16'd7680;
      step_q <= '0;
      mode_q <= MODE_IDLE;
      pend_q <= PEND_NONE;
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_FLOOR_GAIN: floor_q <= cfg_i.data[15:0];
          REG_AUX_GAIN: aux_gain_q <= cfg_i.data[15:0];
          REG_FADE_STEPS: steps_q <= cfg_i.data[15:0];
          REG_RAMP_STEP: step_q <= cfg_i.data[GainW-1:0];
          default: ;
        endcase
      end
    end
  end

  sdfm_gain_mac #(
    .SampleBits(SAMPLE_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (in_i.valid),
    .op_ready_o  (op_ready),
    .main_i      (SAMPLE_BITS'(in_i.main_sample)),
    .aux_i       (SAMPLE_BITS'(in_i.aux_sample)),
    .main_gain_i (gm),
    .aux_gain_i  (ga),
    .ctrl_i      (ctrl),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_sample_o(out_o.out_sample),
    .res_ctrl_o  (res_ctrl)
  );

  assign out_o.mode_now = res_ctrl.mode;
  assign out_o.status = res_ctrl.status;

`ifndef SYNTH
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.op == OP_START && mode_q != MODE_IDLE)
      |=> ($stable(mode_q) && $stable(cnt_q) && $stable(acc_q)))
    else $error("rejected start changed the fade state");

  a_count_clear_outside_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE || mode_q == MODE_MIX) |-> (cnt_q == '0))
    else $error("fade count not clear outside a fade");

  a_accum_follows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (acc_q == '0))
    else $error("ramp accumulator set with fade count at zero");
`endif

endmodule

// ===== hw/rtl/sdfm_gain_mac.sv =====
module sdfm_gain_mac #(
  parameter int unsigned SampleBits = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               op_valid_i,
  output logic                               op_ready_o,
  input  logic signed [SampleBits-1:0]       main_i,
  input  logic signed [SampleBits-1:0]       aux_i,
  input  logic [sdfm_pkg::GainW-1:0]         main_gain_i,
  input  logic [sdfm_pkg::GainW-1:0]         aux_gain_i,
  input  sdfm_pkg::res_ctrl_t                ctrl_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic signed [SampleBits-1:0]       res_sample_o,
  output sdfm_pkg::res_ctrl_t                res_ctrl_o
);
  import sdfm_pkg::*;

  localparam int unsigned ProdW = SampleBits + GainW + 1;
  localparam int unsigned SumW = ProdW + 1;
  localparam int unsigned ShW = SumW - 23;

  logic                         v1_q, v2_q, v3_q;
  logic                         en1, en2, en3;
  logic signed [SampleBits-1:0] main_q, aux_q;
  logic [GainW-1:0]             gm_q, ga_q;
  res_ctrl_t                    ctrl1_q, ctrl2_q, ctrl3_q;
  logic signed [ProdW-1:0]      pm_d, pa_d, pm_q, pa_q;
  logic signed [SumW-1:0]       sum, biased;
  logic signed [ShW-1:0]        shifted;
  logic signed [SampleBits-1:0] sat_d, sample_q;

  assign en3 = !v3_q || res_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign op_ready_o = en1;

  assign pm_d = ProdW'(main_q) * $signed({1'b0, gm_q});
  assign pa_d = ProdW'(aux_q) * $signed({1'b0, ga_q});

  always_comb begin
    sum = SumW'(pm_q) + SumW'(pa_q);
    biased = sum[SumW-1] ? sum + SumW'(24'h7FFFFF) : sum;
    shifted = ShW'(biased >>> 23);
    if (shifted[ShW-1:SampleBits-1] == '0 || shifted[ShW-1:SampleBits-1] == '1) begin
      sat_d = shifted[SampleBits-1:0];
    end else if (shifted[ShW-1]) begin
      sat_d = {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SampleBits-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= op_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && op_valid_i) begin
      main_q <= main_i;
      aux_q <= aux_i;
      gm_q <= main_gain_i;
      ga_q <= aux_gain_i;
      ctrl1_q <= ctrl_i;
    end
    if (en2 && v1_q) begin
      pm_q <= pm_d;
      pa_q <= pa_d;
      ctrl2_q <= ctrl1_q;
    end
    if (en3 && v2_q) begin
      sample_q <= sat_d;
      ctrl3_q <= ctrl2_q;
    end
  end

  assign res_valid_o = v3_q;
  assign res_sample_o = sample_q;
  assign res_ctrl_o = ctrl3_q;

endmodule

// ===== bench/stream_duck_fade_mixer_tb.sv =====
`timescale 1ns / 100ps

module stream_duck_fade_mixer_tb;
  import sdfm_pkg::*;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerSetting = 180;
  localparam longint Q15 = 32768;
  localparam longint Q23 = 8388608;
  localparam longint AccTop = 16777215;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] main_s;
    logic [15:0] aux_s;
    logic        aux_on;
  } mix_item_t;

  typedef struct packed {
    logic [15:0] smp;
    logic [1:0]  mode;
    logic        status;
  } mix_res_t;

  logic clk_i;
  logic rst_ni;

  sdfm_in_if #(.SampleBits(SampleW)) in_if ();
  sdfm_out_if #(.SampleBits(SampleW)) out_if ();
  sdfm_cfg_if cfg_if ();

  stream_duck_fade_mixer #(
    .SAMPLE_BITS(SampleW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  mix_item_t   item_q[$];
  mix_res_t    expected_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned res_idx = 0;
  int unsigned stall_cycles = 0;
  logic        in_fire = 1'b0;

  logic [15:0] floor_reg;
  logic [15:0] auxg_reg;
  logic [15:0] steps_reg;
  logic [23:0] ramp_reg;
  logic [1:0]  duck_mode;
  logic [1:0]  duck_pend;
  longint      fade_cnt;
  longint      gain_acc;

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void finish_fade(input logic [1:0] next_mode);
    fade_cnt = 0;
    gain_acc = 0;
    duck_mode = next_mode;
  endfunction

  function automatic mix_res_t mix_predict(input mix_item_t it);
    mix_res_t r;
    longint   mv;
    longint   av;
    longint   fl;
    longint   ag;
    longint   fl23;
    longint   g;
    longint   acc;
    longint   steps;
    r = '0;
    mv = longint'($signed(it.main_s));
    av = longint'($signed(it.aux_s));
    fl = (floor_reg > UNITY15) ? Q15 : longint'(floor_reg);
    ag = (auxg_reg > UNITY15) ? Q15 : longint'(auxg_reg);
    steps = longint'(steps_reg);
    if (it.op == OP_START) begin
      if (duck_mode != MODE_IDLE) begin
        r.status = 1'b1;
      end else begin
        duck_pend = MODE_FOUT;
        fade_cnt = 0;
        gain_acc = 0;
      end
    end else if (it.op == OP_STOP || it.op == OP_AUX_END) begin
      duck_pend = MODE_FIN;
    end else begin
      if (duck_mode == MODE_FOUT && fade_cnt >= steps) finish_fade(MODE_MIX);
      if (duck_mode == MODE_MIX && duck_pend == MODE_FOUT) begin
        duck_pend = PEND_NONE;
      end else if (duck_mode == MODE_IDLE && duck_pend == MODE_FIN) begin
        duck_pend = PEND_NONE;
      end else if (duck_pend != PEND_NONE) begin
        duck_mode = duck_pend;
        duck_pend = PEND_NONE;
      end
      if (duck_mode == MODE_FOUT || duck_mode == MODE_FIN) begin
        if (fade_cnt < steps) begin
          fl23 = fl * 256;
          if (duck_mode == MODE_FIN) begin
            g = fl23 + gain_acc;
            if (g > Q23) g = Q23;
          end else begin
            g = (gain_acc > Q23) ? 0 : Q23 - gain_acc;
            if (g < fl23) g = fl23;
          end
          r.smp = clip16((mv * g) / Q23);
          fade_cnt = fade_cnt + 1;
          acc = gain_acc + longint'(ramp_reg);
          gain_acc = (acc > AccTop) ? AccTop : acc;
        end else begin
          r.smp = clip16(mv);
        end
        if (fade_cnt >= steps) finish_fade((duck_mode == MODE_FIN) ? MODE_IDLE : MODE_MIX);
      end else if (duck_mode == MODE_MIX) begin
        acc = mv * fl;
        if (it.aux_on) acc += av * ag;
        r.smp = clip16(acc / Q15);
      end else begin
        r.smp = clip16(mv);
      end
    end
    r.mode = duck_mode;
    return r;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(19))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [15:0] main_s,
                           input logic [15:0] aux_s, input logic aux_on);
    mix_item_t it;
    it.op = op;
    it.main_s = main_s;
    it.aux_s = aux_s;
    it.aux_on = aux_on;
    item_q.push_back(it);
  endtask

  task automatic push_sample();
    push_item(OP_SAMPLE, rand_sample(), rand_sample(), 1'($urandom_range(1)));
  endtask

  task automatic push_cmd(input logic [1:0] op);
    push_item(op, rand_sample(), rand_sample(), 1'($urandom_range(1)));
  endtask

  // Mostly complete duck sessions with random content, the rest random noise.
  task automatic push_random(input int unsigned n);
    int unsigned cnt;
    int unsigned flen;
    cnt = 0;
    while (cnt < n) begin
      flen = (steps_reg < 20) ? int'(steps_reg) + 2 : 20;
      if ($urandom_range(99) < 75) begin
        push_cmd(OP_START);
        cnt++;
        repeat ($urandom_range(flen)) begin
          if ($urandom_range(9) == 0) begin
            push_cmd(2'($urandom_range(1, 3)));
            cnt++;
          end
          push_sample();
          cnt++;
        end
        repeat ($urandom_range(6)) begin
          push_sample();
          cnt++;
        end
        push_cmd(($urandom_range(1) == 0) ? OP_STOP : OP_AUX_END);
        cnt++;
        repeat ($urandom_range(flen)) begin
          push_sample();
          cnt++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_cmd(2'($urandom_range(3)));
          cnt++;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_FLOOR_GAIN: floor_reg = val[15:0];
      REG_AUX_GAIN: auxg_reg = val[15:0];
      REG_FADE_STEPS: steps_reg = val[15:0];
      default: ramp_reg = val;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned fl, input int unsigned ag,
                          input int unsigned steps, input int unsigned ramp);
    write_reg(REG_FLOOR_GAIN, 24'(fl));
    write_reg(REG_AUX_GAIN, 24'(ag));
    write_reg(REG_FADE_STEPS, 24'(steps));
    write_reg(REG_RAMP_STEP, 24'(ramp));
  endtask

  task automatic set_random_regs();
    int unsigned fl;
    int unsigned steps;
    fl = $urandom_range(32768);
    steps = $urandom_range(2, 40);
    set_regs(fl, $urandom_range(32768), steps, ((32768 - fl) * 256) / steps);
  endtask

  task automatic settle();
    while (item_q.size() != 0 || in_if.valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) expected_q.push_back(mix_predict(
        {in_if.op, in_if.main_sample, in_if.aux_sample, in_if.aux_valid}));
    in_fire <= rst_ni && in_if.valid && in_if.ready;
  end

  always @(negedge clk_i) begin
    mix_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = item_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.op <= nxt.op;
        in_if.main_sample <= nxt.main_s;
        in_if.aux_sample <= nxt.aux_s;
        in_if.aux_valid <= nxt.aux_on;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    mix_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("result %0d unexpected: sample %0d mode %0d status %0d", res_idx,
                   $signed(out_if.out_sample), out_if.mode_now, out_if.status);
        end
      end else begin
        want = expected_q.pop_front();
        if (out_if.out_sample !== want.smp || out_if.mode_now !== want.mode ||
            out_if.status !== want.status) begin
          err_count++;
          if (err_count <= 10) begin
            $display("result %0d: expected sample %0d mode %0d status %0d, got %0d %0d %0d",
                     res_idx, $signed(want.smp), want.mode, want.status,
                     $signed(out_if.out_sample), out_if.mode_now, out_if.status);
          end
        end
      end
      res_idx++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("stream_duck_fade_mixer_tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_SAMPLE;
    in_if.main_sample = '0;
    in_if.aux_sample = '0;
    in_if.aux_valid = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FLOOR_GAIN;
    cfg_if.data = '0;
    floor_reg = UNITY15;
    auxg_reg = UNITY15;
    steps_reg = 16'd7680;
    ramp_reg = '0;
    duck_mode = MODE_IDLE;
    duck_pend = PEND_NONE;
    fade_cnt = 0;
    gain_acc = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 32;
    snk_idle_pct = 55;
    set_regs(16384, 32768, 4, 1048576);
    push_item(OP_SAMPLE, 16'h7fff, 16'h0000, 1'b0);
    push_item(OP_SAMPLE, 16'h8000, 16'h7fff, 1'b1);
    push_item(OP_STOP, 16'h1234, 16'h4321, 1'b0);
    push_item(OP_SAMPLE, 16'd1000, 16'hffff, 1'b1);
    push_item(OP_START, 16'h0000, 16'h0000, 1'b0);
    push_item(OP_SAMPLE, 16'h7fff, 16'h0000, 1'b0);
    push_item(OP_START, 16'hffff, 16'hffff, 1'b1);
    push_item(OP_SAMPLE, 16'h8000, 16'h0000, 1'b0);
    push_item(OP_STOP, 16'h0000, 16'h0000, 1'b0);
    push_item(OP_SAMPLE, 16'd12345, 16'h0000, 1'b0);
    push_item(OP_SAMPLE, 16'hffff, 16'h0000, 1'b0);
    push_item(OP_START, 16'h0000, 16'h0000, 1'b0);
    repeat (4) push_item(OP_SAMPLE, 16'h7fff, 16'h8000, 1'b1);
    push_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 1'b1);
    push_item(OP_SAMPLE, 16'h8000, 16'h8000, 1'b1);
    push_item(OP_SAMPLE, 16'd20000, 16'd5, 1'b0);
    push_item(OP_START, 16'h0000, 16'h0000, 1'b0);
    push_item(OP_AUX_END, 16'h0000, 16'h0000, 1'b0);
    repeat (4) push_item(OP_SAMPLE, 16'h8000, 16'h7fff, 1'b1);
    settle();

    set_regs(0, 32768, 8, 1048576);
    push_random(ItemsPerSetting);
    settle();
    set_regs(32768, 0, 1, 0);
    push_random(ItemsPerSetting);
    settle();

    src_idle_pct = 55;
    snk_idle_pct = 32;
    set_regs(8192, 16384, 16, 8388608);
    push_random(ItemsPerSetting);
    settle();
    set_regs(24576, 32768, 65535, 1);
    push_random(ItemsPerSetting);
    settle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_random_regs();
    push_random(ItemsPerSetting);
    settle();
    set_random_regs();
    push_random(ItemsPerSetting);
    settle();

    if (err_count == 0) begin
      $display("stream_duck_fade_mixer_tb: done, clean");
    end else begin
      $display("stream_duck_fade_mixer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sdfm_pkg.sv
hw/rtl/sdfm_if.sv
hw/rtl/sdfm_gain_mac.sv
hw/rtl/stream_duck_fade_mixer.sv
bench/stream_duck_fade_mixer_tb.sv
